// ===== rtl/ppsd_pkg.sv =====
package ppsd_pkg;

	// one second in microseconds
	localparam logic [19:0] SEC_US = 20'd1000000;

	// 2^20, 2^40 and 2^60 reduced modulo one second
	localparam logic [15:0] FOLD20 = 16'd48576;
	localparam logic [19:0] FOLD40 = 20'd627776;
	localparam logic [19:0] FOLD60 = 20'd846976;

	// floor(2^32 / 15625), quotient estimate after dropping six low bits
	localparam logic [18:0] RECIP = 19'd274877;

	// classification thresholds
	localparam logic [19:0] IGNORE_LO  = 20'd2;
	localparam logic [19:0] IGNORE_HI  = 20'd999998;
	localparam logic [19:0] DEAD_ZONE  = 20'd20;
	localparam logic [19:0] EXTREME_LO = 20'd200000;
	localparam logic [19:0] EXTREME_HI = 20'd800000;
	localparam logic [19:0] RESYNC_LO  = 20'd450000;
	localparam logic [19:0] RESYNC_HI  = 20'd550000;

	// register reset values
	localparam logic [16:0] NEAR_WIN_RST = 17'd1000;
	localparam logic [16:0] UNUS_LIM_RST = 17'd100;

	// command codes
	localparam logic CMD_EDGE  = 1'b0;
	localparam logic CMD_APPLY = 1'b1;

	typedef enum logic [2:0] {
		ST_INVALID = 3'd0,
		ST_OK      = 3'd1,
		ST_UNUSUAL = 3'd2,
		ST_WAITING = 3'd3,
		ST_EXTREME = 3'd4,
		ST_RESYNC  = 3'd5,
		ST_BROKEN  = 3'd6
	} status_t;

	typedef enum logic [1:0] {
		CFG_FORWARD_ONLY = 2'd0,
		CFG_TRUST_PPS    = 2'd1,
		CFG_NEAR_WINDOW  = 2'd2,
		CFG_UNUSUAL_LIM  = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		CORR_NONE = 2'd0,
		CORR_BACK = 2'd1,
		CORR_FWD  = 2'd2
	} corr_t;

endpackage

// ===== rtl/pps_clock_phase_discipline_unit.sv =====
// pps clock phase discipline: each item is either a pulse edge (command 0, carrying the
// disciplined time in us at the edge) or an apply (command 1). an edge item takes the
// phase error edge_time_us mod 1000000, classifies it against the near window, the
// forward-only dead zone and, in trust mode, the extreme and resync windows, and leaves
// a pending correction and a status code; an apply item adds the pending correction to
// the signed 64-bit offset and clears it. every item gives exactly one result holding
// status, pending correction and offset after that item. the block takes one item per
// cycle while the result side does not stall; an accepted item sits in the input
// register, passes seven modulo stages (fold by constant residues of 2^20, 2^40 and
// 2^60, sum of the residues, two more folds, reciprocal quotient estimate, partial
// remainder, one correcting subtract) and is classified into the state register.
// stalls on the result side back up stage by stage, so bubbles are squeezed out before
// the input side sees back-pressure. configuration writes are always taken at once and
// should only be made while no item is in flight.
module pps_clock_phase_discipline_unit (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [16:0] cfg_data,
	// input item channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [62:0] edge_time_us,
	// result item channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic signed [19:0] pending_correction,
	output logic signed [63:0] offset_us
);

	localparam int NSTG = 8;

	// configuration registers
	logic        fwd_only_q;
	logic        trust_q;
	logic [16:0] near_win_q;
	logic [16:0] unus_lim_q;

	// architectural state, shown directly on the result ports
	ppsd_pkg::status_t status_q;
	logic signed [19:0] pending_q;
	logic signed [63:0] offset_q;
	logic               out_valid_q;

	// per-stage valid bits and load enables
	logic [NSTG:1] vld_q;
	logic [NSTG:1] free;
	logic          free_out;
	logic          done;

	// pipeline payload
	logic        cmd_s1, cmd_s2, cmd_s3, cmd_s4, cmd_s5, cmd_s6, cmd_s7, cmd_s8;
	logic [62:0] t_s1;
	logic [19:0] c0_s2;
	logic [35:0] p1_s2;
	logic [39:0] p2_s2;
	logic [22:0] p3_s2;
	logic [39:0] sum_s3;
	logic [35:0] r_s4;
	logic [31:0] r_s5;
	logic [31:0] r_s6;
	logic [11:0] q_s6;
	logic [20:0] r_s7;
	logic [19:0] dev_s8;

	logic [44:0] qprod;
	logic [31:0] qsub;

	// classification of the phase error
	ppsd_pkg::corr_t   corr;
	ppsd_pkg::status_t err;
	ppsd_pkg::status_t status_new;
	logic [19:0]        fwd_mag;
	logic [19:0]        mag;
	logic [19:0]        late_lim;
	logic signed [19:0] adj;
	logic               mid;

	// config port never stalls
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_only_q <= 1'b0;
			trust_q    <= 1'b0;
			near_win_q <= ppsd_pkg::NEAR_WIN_RST;
			unus_lim_q <= ppsd_pkg::UNUS_LIM_RST;
		end else if (cfg_valid) begin
			unique case (ppsd_pkg::cfg_idx_t'(cfg_index))
				ppsd_pkg::CFG_FORWARD_ONLY: fwd_only_q <= cfg_data[0];
				ppsd_pkg::CFG_TRUST_PPS:    trust_q    <= cfg_data[0];
				ppsd_pkg::CFG_NEAR_WINDOW:  near_win_q <= cfg_data;
				ppsd_pkg::CFG_UNUSUAL_LIM:  unus_lim_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// a stage may load when it is empty or its item moves on
	assign free_out = !out_valid_q || out_ready;
	always_comb begin
		free[NSTG] = !vld_q[NSTG] || free_out;
		for (int k = NSTG - 1; k >= 1; k--) begin
			free[k] = !vld_q[k] || free[k+1];
		end
	end

	assign in_ready = free[1];
	assign done     = vld_q[NSTG] && free_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (free[1]) begin
				vld_q[1] <= in_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (free[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// stage 1: input register
	always_ff @(posedge clk) begin
		if (free[1]) begin
			cmd_s1 <= command;
			t_s1   <= edge_time_us;
		end
	end

	// stage 2: 20-bit chunks times their residues
	always_ff @(posedge clk) begin
		if (free[2]) begin
			cmd_s2 <= cmd_s1;
			c0_s2  <= t_s1[19:0];
			p1_s2  <= 36'(t_s1[39:20]) * 36'(ppsd_pkg::FOLD20);
			p2_s2  <= 40'(t_s1[59:40]) * 40'(ppsd_pkg::FOLD40);
			p3_s2  <= 23'(t_s1[62:60]) * 23'(ppsd_pkg::FOLD60);
		end
	end

	// stage 3: sum of the residues, below 2^40
	always_ff @(posedge clk) begin
		if (free[3]) begin
			cmd_s3 <= cmd_s2;
			sum_s3 <= 40'(c0_s2) + 40'(p1_s2) + p2_s2 + 40'(p3_s2);
		end
	end

	// stage 4: fold bits 39:20 back, below 2^36
	always_ff @(posedge clk) begin
		if (free[4]) begin
			cmd_s4 <= cmd_s3;
			r_s4   <= 36'(sum_s3[19:0]) + 36'(sum_s3[39:20]) * 36'(ppsd_pkg::FOLD20);
		end
	end

	// stage 5: fold bits 35:20 back, below 2^32
	always_ff @(posedge clk) begin
		if (free[5]) begin
			cmd_s5 <= cmd_s4;
			r_s5   <= 32'(r_s4[19:0]) + 32'(r_s4[35:20]) * 32'(ppsd_pkg::FOLD20);
		end
	end

	// stage 6: quotient estimate, true quotient or one less
	assign qprod = 45'(r_s5[31:6]) * 45'(ppsd_pkg::RECIP);

	always_ff @(posedge clk) begin
		if (free[6]) begin
			cmd_s6 <= cmd_s5;
			r_s6   <= r_s5;
			q_s6   <= qprod[43:32];
		end
	end

	// stage 7: partial remainder, below two seconds
	assign qsub = r_s6 - 32'(q_s6) * 32'(ppsd_pkg::SEC_US);

	always_ff @(posedge clk) begin
		if (free[7]) begin
			cmd_s7 <= cmd_s6;
			r_s7   <= qsub[20:0];
		end
	end

	// stage 8: phase error within the second
	always_ff @(posedge clk) begin
		if (free[8]) begin
			cmd_s8 <= cmd_s7;
			if (r_s7 >= 21'(ppsd_pkg::SEC_US)) begin
				dev_s8 <= 20'(r_s7 - 21'(ppsd_pkg::SEC_US));
			end else begin
				dev_s8 <= r_s7[19:0];
			end
		end
	end

	// classification, first matching window wins
	assign mid      = (dev_s8 > ppsd_pkg::IGNORE_LO) && (dev_s8 < ppsd_pkg::IGNORE_HI);
	assign late_lim = ppsd_pkg::SEC_US - 20'(near_win_q);
	assign fwd_mag  = ppsd_pkg::SEC_US - dev_s8;

	always_comb begin
		corr = ppsd_pkg::CORR_NONE;
		err  = ppsd_pkg::ST_INVALID;
		if (mid) begin
			if (fwd_only_q && dev_s8 <= ppsd_pkg::DEAD_ZONE) begin
				corr = ppsd_pkg::CORR_NONE;
			end else if (dev_s8 <= 20'(near_win_q)) begin
				corr = ppsd_pkg::CORR_BACK;
			end else if (dev_s8 >= late_lim) begin
				corr = ppsd_pkg::CORR_FWD;
			end else if (!trust_q) begin
				err = ppsd_pkg::ST_WAITING;
			end else if (dev_s8 <= ppsd_pkg::EXTREME_LO) begin
				corr = ppsd_pkg::CORR_BACK;
				err  = ppsd_pkg::ST_EXTREME;
			end else if (dev_s8 >= ppsd_pkg::EXTREME_HI) begin
				corr = ppsd_pkg::CORR_FWD;
				err  = ppsd_pkg::ST_EXTREME;
			end else if (dev_s8 <= ppsd_pkg::RESYNC_LO) begin
				corr = ppsd_pkg::CORR_BACK;
				err  = ppsd_pkg::ST_RESYNC;
			end else if (dev_s8 >= ppsd_pkg::RESYNC_HI) begin
				corr = ppsd_pkg::CORR_FWD;
				err  = ppsd_pkg::ST_RESYNC;
			end else begin
				err = ppsd_pkg::ST_BROKEN;
			end
		end
	end

	always_comb begin
		case (corr)
			ppsd_pkg::CORR_BACK: begin
				adj = $signed(20'd0 - dev_s8);
				mag = dev_s8;
			end
			ppsd_pkg::CORR_FWD: begin
				adj = $signed(fwd_mag);
				mag = fwd_mag;
			end
			default: begin
				adj = '0;
				mag = '0;
			end
		endcase
	end

	// error codes stick until the next edge, otherwise judge the magnitude
	always_comb begin
		if (err != ppsd_pkg::ST_INVALID) begin
			status_new = err;
		end else if (mag > 20'(unus_lim_q)) begin
			status_new = ppsd_pkg::ST_UNUSUAL;
		end else begin
			status_new = ppsd_pkg::ST_OK;
		end
	end

	// state update doubles as the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q    <= ppsd_pkg::ST_INVALID;
			pending_q   <= '0;
			offset_q    <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (done) begin
				out_valid_q <= 1'b1;
				if (cmd_s8 == ppsd_pkg::CMD_EDGE) begin
					pending_q <= adj;
					status_q  <= status_new;
				end else begin
					offset_q  <= offset_q + 64'(pending_q);
					pending_q <= '0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign status             = status_q;
	assign pending_correction = pending_q;
	assign offset_us          = offset_q;

	// partial remainder never reaches two seconds
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[7] |-> (r_s7 < 21'd2000000))
		else $error("partial remainder out of range");

	// phase error is inside one second
	a_dev_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_q[8] |-> (dev_s8 < ppsd_pkg::SEC_US))
		else $error("phase error not reduced");

	// an apply always leaves nothing pending
	a_apply_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(done && cmd_s8 == ppsd_pkg::CMD_APPLY) |=> (pending_q == '0))
		else $error("pending correction kept after apply");

	// offset moves only on a completed apply
	a_offset_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(done && cmd_s8 == ppsd_pkg::CMD_APPLY) |=> $stable(offset_q))
		else $error("offset changed without apply");

	// no result is overwritten before it is taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !out_ready) |-> !done)
		else $error("result overwritten while stalled");

endmodule
